// File: hdl/pav_pkg.sv
// ----------------------------------------------------------------------------
// pav_pkg
// Types and constants shared by the ACL blob validator modules.
// ----------------------------------------------------------------------------
package pav_pkg;

    localparam int unsigned TOTAL_W = 13;

    localparam logic [7:0]  ACL_VERSION = 8'h02;
    localparam logic [7:0]  ALL_ONES_B  = 8'hFF;

    localparam logic [15:0] TAG_USER_OBJ  = 16'h0001;
    localparam logic [15:0] TAG_USER      = 16'h0002;
    localparam logic [15:0] TAG_GROUP_OBJ = 16'h0004;
    localparam logic [15:0] TAG_GROUP     = 16'h0008;
    localparam logic [15:0] TAG_MASK      = 16'h0010;
    localparam logic [15:0] TAG_OTHER     = 16'h0020;

    localparam logic [1:0] HDR_LAST_IDX = 2'd3;
    localparam logic [2:0] PH_TAG_LO    = 3'd0;
    localparam logic [2:0] PH_TAG_HI    = 3'd1;
    localparam logic [2:0] PH_ID_FIRST  = 3'd4;
    localparam logic [2:0] PH_LAST      = 3'd7;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_SHORT        = 4'd1,
        ST_VERSION      = 4'd2,
        ST_USER_NOID    = 4'd3,
        ST_GROUP_NOID   = 4'd4,
        ST_BADTAG       = 4'd5,
        ST_USER_OBJ     = 4'd6,
        ST_GROUP_OBJ    = 4'd7,
        ST_OTHER        = 4'd8,
        ST_MASK_MISSING = 4'd9,
        ST_MANY_MASKS   = 4'd10
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [3:0]         status;
        logic [TOTAL_W-1:0] entry_total;
    } t_res_word;

    // Events raised by the byte tracker for the current byte
    typedef struct packed {
        logic        hdr_end;    // fourth header byte
        logic        ver_bad;    // version word is not 2
        logic        short_blob; // last byte inside the header
        logic        entry_end;  // final byte of an entry
        logic [15:0] tag;
        logic        id_none;    // id is all ones
    } t_parse_ev;

endpackage

// File: hdl/pav_chan_if.sv
// ----------------------------------------------------------------------------
// pav_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface pav_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/pav_parse.sv
// ----------------------------------------------------------------------------
// pav_parse
// Byte position tracker: assembles header and entry fields.
// ----------------------------------------------------------------------------
module pav_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  pav_pkg::t_in_word   i_word,
    output pav_pkg::t_parse_ev  o_ev
);
    import pav_pkg::*;

    logic        r_hdr_done, n_hdr_done;
    logic [1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [2:0]  r_phase, n_phase;
    logic        r_ver_ok, n_ver_ok;
    logic [15:0] r_tag, n_tag;
    logic        r_id_ones, n_id_ones;

    logic        ver_byte_ok;
    logic        byte_ones;

    always_comb begin
        ver_byte_ok = (r_hdr_cnt == 2'd0) ? (i_word.data_byte == ACL_VERSION)
                                          : (i_word.data_byte == 8'd0);
        byte_ones   = (i_word.data_byte == ALL_ONES_B);

        n_hdr_done = r_hdr_done;
        n_hdr_cnt  = r_hdr_cnt;
        n_phase    = r_phase;
        n_ver_ok   = r_ver_ok;
        n_tag      = r_tag;
        n_id_ones  = r_id_ones;

        o_ev            = '0;
        o_ev.tag        = r_tag;
        o_ev.id_none    = r_id_ones & byte_ones;

        if (!r_hdr_done) begin
            n_ver_ok        = r_ver_ok & ver_byte_ok;
            o_ev.ver_bad    = !n_ver_ok;
            o_ev.hdr_end    = (r_hdr_cnt == HDR_LAST_IDX);
            o_ev.short_blob = (r_hdr_cnt != HDR_LAST_IDX) && i_word.last_byte;
            n_hdr_cnt       = r_hdr_cnt + 2'd1;
            n_hdr_done      = (r_hdr_cnt == HDR_LAST_IDX);
        end else begin
            if (r_phase == PH_TAG_LO) begin
                n_tag = {8'd0, i_word.data_byte};
            end else if (r_phase == PH_TAG_HI) begin
                n_tag = {i_word.data_byte, r_tag[7:0]};
            end
            if (r_phase == PH_ID_FIRST) begin
                n_id_ones = byte_ones;
            end else if (r_phase > PH_ID_FIRST) begin
                n_id_ones = r_id_ones & byte_ones;
            end
            o_ev.entry_end = (r_phase == PH_LAST);
            n_phase        = r_phase + 3'd1;
        end

        // clear all parse state on the final byte of a blob
        if (i_word.last_byte) begin
            n_hdr_done = 1'b0;
            n_hdr_cnt  = 2'd0;
            n_phase    = 3'd0;
            n_ver_ok   = 1'b1;
            n_tag      = '0;
            n_id_ones  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_done <= 1'b0;
            r_hdr_cnt  <= 2'd0;
            r_phase    <= 3'd0;
            r_ver_ok   <= 1'b1;
            r_tag      <= '0;
            r_id_ones  <= 1'b1;
        end else if (i_step) begin
            r_hdr_done <= n_hdr_done;
            r_hdr_cnt  <= n_hdr_cnt;
            r_phase    <= n_phase;
            r_ver_ok   <= n_ver_ok;
            r_tag      <= n_tag;
            r_id_ones  <= n_id_ones;
        end
    end

endmodule

// File: hdl/pav_tally.sv
// ----------------------------------------------------------------------------
// pav_tally
// Entry checks, saturating tag counts and final status of a blob.
// ----------------------------------------------------------------------------
module pav_tally #(
    parameter int unsigned ENTRY_CAP = 8191
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_last,
    input  pav_pkg::t_parse_ev  i_ev,
    output pav_pkg::t_res_word  o_res
);
    import pav_pkg::*;

    localparam int unsigned CNT_W = $clog2(ENTRY_CAP + 1);

    logic [1:0]       r_uobj_cnt, n_uobj_cnt;
    logic [1:0]       r_gobj_cnt, n_gobj_cnt;
    logic [1:0]       r_other, n_other;
    logic [1:0]       r_mask, n_mask;
    logic             r_named, n_named;
    t_status          r_err, n_err;
    logic [CNT_W-1:0] r_entries, n_entries;
    t_status          fin;

    function automatic logic [1:0] sat_inc(input logic [1:0] c);
        return (c == 2'd3) ? 2'd3 : c + 2'd1;
    endfunction

    always_comb begin
        n_uobj_cnt  = r_uobj_cnt;
        n_gobj_cnt  = r_gobj_cnt;
        n_other     = r_other;
        n_mask      = r_mask;
        n_named     = r_named;
        n_err       = r_err;
        n_entries   = r_entries;

        if (i_ev.hdr_end && i_ev.ver_bad && r_err == ST_OK) begin
            n_err = ST_VERSION;
        end

        if (i_ev.entry_end) begin
            if (r_entries != CNT_W'(ENTRY_CAP)) begin
                n_entries = r_entries + CNT_W'(1);
            end
            // keep the first error: later entries are only counted
            if (r_err == ST_OK) begin
                case (i_ev.tag)
                    TAG_USER_OBJ:  n_uobj_cnt = sat_inc(r_uobj_cnt);
                    TAG_USER: begin
                        if (i_ev.id_none) n_err = ST_USER_NOID;
                        else              n_named = 1'b1;
                    end
                    TAG_GROUP_OBJ: n_gobj_cnt = sat_inc(r_gobj_cnt);
                    TAG_GROUP: begin
                        if (i_ev.id_none) n_err = ST_GROUP_NOID;
                        else              n_named = 1'b1;
                    end
                    TAG_MASK:      n_mask = sat_inc(r_mask);
                    TAG_OTHER:     n_other = sat_inc(r_other);
                    default:       n_err = ST_BADTAG;
                endcase
            end
        end

        if (n_err != ST_OK)                      fin = n_err;
        else if (n_uobj_cnt != 2'd1)             fin = ST_USER_OBJ;
        else if (n_gobj_cnt != 2'd1)             fin = ST_GROUP_OBJ;
        else if (n_other != 2'd1)                fin = ST_OTHER;
        else if (n_named && n_mask != 2'd1)      fin = ST_MASK_MISSING;
        else if (n_mask > 2'd1)                  fin = ST_MANY_MASKS;
        else                                     fin = ST_OK;

        if (i_ev.short_blob) begin
            o_res.status      = ST_SHORT;
            o_res.entry_total = '0;
        end else begin
            o_res.status      = fin;
            o_res.entry_total = TOTAL_W'(n_entries);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_uobj_cnt  <= 2'd0;
            r_gobj_cnt  <= 2'd0;
            r_other     <= 2'd0;
            r_mask      <= 2'd0;
            r_named     <= 1'b0;
            r_err       <= ST_OK;
            r_entries   <= '0;
        end else if (i_step) begin
            r_uobj_cnt  <= n_uobj_cnt;
            r_gobj_cnt  <= n_gobj_cnt;
            r_other     <= n_other;
            r_mask      <= n_mask;
            r_named     <= n_named;
            r_err       <= n_err;
            r_entries   <= n_entries;
        end
    end

endmodule

// File: hdl/posix_acl_blob_validator.sv
// Path: the last byte of a blob is accepted into the input register; its result
//   word then goes into the result register and appears on o_res_if.
// Throughput: one byte per cycle; the per-byte check sits between the input
//   register and the result register, and a waiting result stalls only the
//   next last byte.
// Reset: synchronous, active low; clears all blob state and both valids.
// ----------------------------------------------------------------------------
// posix_acl_blob_validator
// Checks a POSIX ACL xattr blob, one byte per word, and reports one status.
// ----------------------------------------------------------------------------
module posix_acl_blob_validator #(
    parameter int unsigned MAX_ENTRIES = 8191
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pav_chan_if.sink          i_byte_if,
    pav_chan_if.source        o_res_if
);
    import pav_pkg::*;

    localparam int unsigned ENTRY_CAP = (MAX_ENTRIES < 8191) ? MAX_ENTRIES : 8191;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_res_word r_out_word;

    logic      advance;
    logic      step;
    t_parse_ev ev;
    t_res_word res;

    // a byte without the last mark never needs the result register
    assign advance = !r_in_word.last_byte || !r_out_valid || o_res_if.ready;
    assign step    = r_in_valid && advance;

    assign i_byte_if.ready = !r_in_valid || advance;
    assign o_res_if.valid  = r_out_valid;
    assign o_res_if.data   = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_if.ready) begin
            r_in_valid <= i_byte_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_if.ready && i_byte_if.valid) begin
            r_in_word <= i_byte_if.data;
        end
    end

    pav_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in_word),
        .o_ev    (ev)
    );

    pav_tally #(
        .ENTRY_CAP (ENTRY_CAP)
    ) u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_last  (r_in_word.last_byte),
        .i_ev    (ev),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_word.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_res_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_word.last_byte) begin
            r_out_word <= res;
        end
    end

endmodule

// File: dv/tb_posix_acl_blob_validator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_posix_acl_blob_validator
// Self-checking bench for the ACL blob validator. Blobs go in one byte per
// word: first a table of hand-built cases, then blobs built at random, mostly
// well-formed ACLs with random faults. Typed cases carry their own verdict; a
// byte-level model of the parser predicts the rest, and every result word is checked in order.
// ----------------------------------------------------------------------------
module tb_posix_acl_blob_validator;
    import pav_pkg::*;

    localparam int MAX_ENTRIES = 8191;
    localparam int ENTRY_CAP   = (MAX_ENTRIES < 8191) ? MAX_ENTRIES : 8191;
    localparam int WATCHDOG    = 2000;
    localparam int RX_HOLD     = 400;

    typedef struct packed {
        logic      typed;
        t_res_word res;
    } t_blob_note;

    typedef struct {
        logic [31:0] ver;
        int          n_ent;
        logic [15:0] tags [6];
        logic [31:0] ids [6];
        int          n_fill;    // MASK entries appended after the listed ones
        int          tail;      // stray bytes of an unfinished entry
        int          cut;       // nonzero: keep only this many bytes
        logic        typed;
        t_status     exp_st;
        int          exp_total;
    } t_acl_case;

    logic i_clk;
    logic i_rst_n;

    pav_chan_if #(.T(t_in_word))  byte_if ();
    pav_chan_if #(.T(t_res_word)) res_if ();

    posix_acl_blob_validator #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_if (byte_if),
        .o_res_if  (res_if)
    );

    t_acl_case dir_cases [19] = '{
        // blob ends inside the header
        '{32'd2, 0, '{6{16'h0}}, '{6{32'h0}}, 0, 0, 1, 1'b1, ST_SHORT, 0},
        '{32'hFFFF_FFFF, 0, '{6{16'h0}}, '{6{32'h0}}, 0, 0, 3, 1'b1, ST_SHORT, 0},
        // header only
        '{32'd2, 0, '{6{16'h0}}, '{6{32'h0}}, 0, 0, 0, 1'b1, ST_USER_OBJ, 0},
        '{32'h0200_0000, 0, '{6{16'h0}}, '{6{32'h0}}, 0, 0, 0, 1'b1, ST_VERSION, 0},
        // minimal ACL; the id of an owner entry is not looked at
        '{32'd2, 3, '{TAG_USER_OBJ, TAG_GROUP_OBJ, TAG_OTHER, 16'h0, 16'h0, 16'h0},
          '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 0, 0, 0, 1'b1, ST_OK, 3},
        '{32'd2, 1, '{TAG_USER, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
          '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 0, 0, 0,
          1'b1, ST_USER_NOID, 1},
        '{32'd2, 1, '{TAG_GROUP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
          '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 0, 0, 0,
          1'b1, ST_GROUP_NOID, 1},
        // known low byte with the high byte set is still an unknown tag
        '{32'd2, 1, '{16'h0101, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
          '{6{32'h0}}, 0, 0, 0, 1'b1, ST_BADTAG, 1},
        // the first error wins over later ones
        '{32'd0, 2, '{TAG_USER_OBJ, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0},
          '{6{32'h0}}, 0, 0, 0, 1'b1, ST_VERSION, 2},
        '{32'd2, 3, '{TAG_USER, 16'h0000, TAG_GROUP, 16'h0, 16'h0, 16'h0},
          '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 0, 0, 0,
          1'b1, ST_USER_NOID, 3},
        // owner count saturates but stays wrong
        '{32'd2, 4, '{TAG_USER_OBJ, TAG_USER_OBJ, TAG_USER_OBJ, TAG_USER_OBJ,
                     16'h0, 16'h0},
          '{6{32'h0}}, 0, 0, 0, 1'b1, ST_USER_OBJ, 4},
        '{32'd2, 2, '{TAG_USER_OBJ, TAG_OTHER, 16'h0, 16'h0, 16'h0, 16'h0},
          '{6{32'h0}}, 0, 0, 0, 1'b1, ST_GROUP_OBJ, 2},
        '{32'd2, 4, '{TAG_USER_OBJ, TAG_GROUP_OBJ, TAG_OTHER, TAG_OTHER, 16'h0, 16'h0},
          '{6{32'h0}}, 0, 0, 0, 1'b1, ST_OTHER, 4},
        // named entries need exactly one mask
        '{32'd2, 4, '{TAG_USER_OBJ, TAG_USER, TAG_GROUP_OBJ, TAG_OTHER, 16'h0, 16'h0},
          '{32'h0, 32'd5, 32'h0, 32'h0, 32'h0, 32'h0}, 0, 0, 0,
          1'b1, ST_MASK_MISSING, 4},
        '{32'd2, 6, '{TAG_USER_OBJ, TAG_GROUP, TAG_GROUP_OBJ, TAG_MASK, TAG_MASK, TAG_OTHER},
          '{32'h0, 32'd9, 32'h0, 32'h0, 32'h0, 32'h0}, 0, 0, 0,
          1'b1, ST_MASK_MISSING, 6},
        '{32'd2, 5, '{TAG_USER_OBJ, TAG_GROUP_OBJ, TAG_MASK, TAG_MASK, TAG_OTHER, 16'h0},
          '{6{32'h0}}, 0, 0, 0, 1'b1, ST_MANY_MASKS, 5},
        // partial entry left over
        '{32'd2, 3, '{TAG_USER_OBJ, TAG_USER, TAG_MASK, 16'h0, 16'h0, 16'h0},
          '{32'h0, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0, 32'h0}, 0, 7, 0,
          1'b0, ST_OK, 0},
        '{32'd2, 0, '{6{16'h0}}, '{6{32'h0}}, 0, 5, 0, 1'b0, ST_OK, 0},
        // a single mask without named entries is fine
        '{32'd2, 3, '{TAG_USER_OBJ, TAG_GROUP_OBJ, TAG_OTHER, 16'h0, 16'h0, 16'h0},
          '{6{32'h0}}, 1, 0, 0, 1'b1, ST_OK, 4}
    };

    // parser state of the predictor
    logic [1:0]  hdr_idx;
    logic        hdr_done;
    logic [2:0]  ent_ph;
    logic [31:0] ver_acc;
    logic [15:0] tag_acc;
    logic [31:0] id_acc;
    logic [1:0]  cnt_uobj, cnt_gobj, cnt_other, cnt_mask;
    logic        named_seen;
    t_status     err_first;
    logic [12:0] cnt_entries;

    t_res_word   verdict_q [$];
    t_blob_note  blob_note_q [$];
    logic [7:0]  blob_buf [$];
    logic [63:0] ent_buf [$];

    int err_cnt     = 0;
    int tx_idle_pct = 32;
    int rx_idle_pct = 32;
    bit rx_hold_req = 1'b0;

    function automatic logic [1:0] sat3(logic [1:0] c);
        return (c == 2'd3) ? c : c + 2'd1;
    endfunction

    function void acl_clear();
        hdr_idx     = '0;
        hdr_done    = 1'b0;
        ent_ph      = '0;
        ver_acc     = '0;
        tag_acc     = '0;
        id_acc      = '0;
        cnt_uobj    = '0;
        cnt_gobj    = '0;
        cnt_other   = '0;
        cnt_mask    = '0;
        named_seen  = 1'b0;
        err_first   = ST_OK;
        cnt_entries = '0;
    endfunction

    function void acl_count_entry();
        case (tag_acc)
            TAG_USER_OBJ:  cnt_uobj = sat3(cnt_uobj);
            TAG_GROUP_OBJ: cnt_gobj = sat3(cnt_gobj);
            TAG_MASK:      cnt_mask = sat3(cnt_mask);
            TAG_OTHER:     cnt_other = sat3(cnt_other);
            TAG_USER: begin
                if (&id_acc) err_first = ST_USER_NOID;
                else named_seen = 1'b1;
            end
            TAG_GROUP: begin
                if (&id_acc) err_first = ST_GROUP_NOID;
                else named_seen = 1'b1;
            end
            default: err_first = ST_BADTAG;
        endcase
    endfunction

    function t_status acl_verdict();
        if (err_first != ST_OK) return err_first;
        if (cnt_uobj != 2'd1) return ST_USER_OBJ;
        if (cnt_gobj != 2'd1) return ST_GROUP_OBJ;
        if (cnt_other != 2'd1) return ST_OTHER;
        if (named_seen && cnt_mask != 2'd1) return ST_MASK_MISSING;
        if (cnt_mask > 2'd1) return ST_MANY_MASKS;
        return ST_OK;
    endfunction

    // Advance the parser by one byte; returns 1 with the verdict on a last byte.
    function automatic logic acl_take_byte(input t_in_word w, output t_res_word r);
        logic short_b;
        short_b = 1'b0;
        r = '0;
        if (!hdr_done) begin
            ver_acc[8*hdr_idx +: 8] = w.data_byte;
            if (hdr_idx == HDR_LAST_IDX) begin
                hdr_done = 1'b1;
                if (ver_acc != {24'd0, ACL_VERSION} && err_first == ST_OK)
                    err_first = ST_VERSION;
            end else if (w.last_byte) begin
                short_b = 1'b1;
            end
            hdr_idx = hdr_idx + 2'd1;
        end else begin
            if (ent_ph < 3'd2) tag_acc[8*ent_ph +: 8] = w.data_byte;
            else if (ent_ph >= PH_ID_FIRST) id_acc[8*(ent_ph-PH_ID_FIRST) +: 8] = w.data_byte;
            if (ent_ph == PH_LAST) begin
                if (cnt_entries < ENTRY_CAP) cnt_entries = cnt_entries + 13'd1;
                if (err_first == ST_OK) acl_count_entry();
                tag_acc = '0;
                id_acc  = '0;
            end
            ent_ph = ent_ph + 3'd1;
        end
        if (!w.last_byte) return 1'b0;
        r.status      = short_b ? ST_SHORT : acl_verdict();
        r.entry_total = short_b ? '0 : cnt_entries;
        acl_clear();
        return 1'b1;
    endfunction

    function void put_le(logic [31:0] v, int nbytes);
        for (int k = 0; k < nbytes; k++) blob_buf.push_back(v[8*k +: 8]);
    endfunction

    function void put_entry(logic [15:0] tag, logic [15:0] perm, logic [31:0] id);
        put_le({16'h0, tag}, 2);
        put_le({16'h0, perm}, 2);
        put_le(id, 4);
    endfunction

    function void build_case(t_acl_case c);
        blob_buf.delete();
        put_le(c.ver, 4);
        for (int i = 0; i < c.n_ent; i++)
            put_entry(c.tags[i], i[0] ? 16'hFFFF : 16'h0000, c.ids[i]);
        for (int i = 0; i < c.n_fill; i++)
            put_entry(TAG_MASK, 16'h0006, i);
        repeat (c.tail) blob_buf.push_back(8'($urandom));
        if (c.cut > 0)
            while (blob_buf.size() > c.cut) void'(blob_buf.pop_back());
    endfunction

    // one most of the time, otherwise anything up to three
    function automatic int usual_one();
        return ($urandom_range(0, 99) < 15) ? $urandom_range(0, 3) : 1;
    endfunction

    function automatic void place_entry(logic [15:0] tag, logic [31:0] id, logic mix);
        int pos;
        pos = mix ? $urandom_range(0, ent_buf.size()) : ent_buf.size();
        ent_buf.insert(pos, {tag, 16'($urandom), id});
    endfunction

    function automatic logic [31:0] named_id();
        return ($urandom_range(0, 19) == 0) ? 32'hFFFF_FFFF : $urandom;
    endfunction

    function automatic void build_random_blob();
        int          kind, n_nu, n_ng, n_mk;
        logic        mix;
        logic [31:0] ver;
        logic [15:0] odd_tag;
        blob_buf.delete();
        ent_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // noise
            repeat ($urandom_range(1, 40)) blob_buf.push_back(8'($urandom));
            return;
        end
        if (kind < 14) begin
            repeat ($urandom_range(1, 3)) blob_buf.push_back(8'($urandom));
            return;
        end
        case ($urandom_range(0, 19))
            0:       ver = $urandom;
            1:       ver = 32'd2 ^ (32'd1 << $urandom_range(0, 31));
            default: ver = 32'd2;
        endcase
        mix  = ($urandom_range(0, 3) == 0);
        n_nu = $urandom_range(0, 2);
        n_ng = $urandom_range(0, 2);
        n_mk = (n_nu + n_ng > 0) ? usual_one() : (($urandom_range(0, 4) == 0) ? usual_one() : 0);
        repeat (usual_one()) place_entry(TAG_USER_OBJ, $urandom, mix);
        repeat (n_nu) place_entry(TAG_USER, named_id(), mix);
        repeat (usual_one()) place_entry(TAG_GROUP_OBJ, $urandom, mix);
        repeat (n_ng) place_entry(TAG_GROUP, named_id(), mix);
        repeat (n_mk) place_entry(TAG_MASK, $urandom, mix);
        repeat (usual_one()) place_entry(TAG_OTHER, $urandom, mix);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0:       odd_tag = 16'($urandom);
                1:       odd_tag = 16'h1 << $urandom_range(6, 15);
                default: odd_tag = 16'h0100 | TAG_MASK;
            endcase
            place_entry(odd_tag, $urandom, 1'b1);
        end
        put_le(ver, 4);
        foreach (ent_buf[i]) put_entry(ent_buf[i][63:48], ent_buf[i][47:32], ent_buf[i][31:0]);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 7)) blob_buf.push_back(8'($urandom));
    endfunction

    // Offer one word, with random idle cycles ahead of it; return once accepted.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.data  <= w;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
    endtask

    task automatic send_blob(input logic typed, input t_res_word res);
        t_in_word w;
        blob_note_q.push_back('{typed: typed, res: res});
        foreach (blob_buf[i]) begin
            w.data_byte = blob_buf[i];
            w.last_byte = (i == blob_buf.size() - 1);
            send_word(w);
        end
    endtask

    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (verdict_q.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, plus one long hold on request.
    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_res_word  pred, want, got;
        t_blob_note note;
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                if (acl_take_byte(byte_if.data, pred)) begin
                    note = blob_note_q.pop_front();
                    verdict_q.push_back(note.typed ? note.res : pred);
                end
            end
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (verdict_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual status %0d total %0d",
                             $time, got.status, got.entry_total);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.status != want.status) begin
                        err_cnt++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.entry_total != want.entry_total) begin
                        err_cnt++;
                        $display("%0t: entry_total mismatch, expected %0d actual %0d",
                                 $time, want.entry_total, got.entry_total);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet, verdict_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int        blob_no;
        t_res_word typed_res;
        acl_clear();
        i_rst_n       <= 1'b0;
        byte_if.valid <= 1'b0;
        byte_if.data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_cases[i]) begin
            build_case(dir_cases[i]);
            typed_res.status      = dir_cases[i].exp_st;
            typed_res.entry_total = dir_cases[i].exp_total[TOTAL_W-1:0];
            send_blob(dir_cases[i].typed, typed_res);
        end
        wait_drained();

        blob_no = 0;
        while (blob_no < 5) begin
            // a long stretch with no idling on either side
            if (blob_no == 0) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (blob_no == 2) begin
                tx_idle_pct = 32;
                rx_idle_pct = 32;
            end
            // hold results back while short blobs keep coming, so the input stalls
            if (blob_no == 2) begin
                rx_hold_req = 1'b1;
                repeat (6) begin
                    blob_buf.delete();
                    blob_buf.push_back(8'($urandom));
                    send_blob(1'b0, '0);
                end
            end
            if (blob_no == 3) wait_drained();
            build_random_blob();
            send_blob(1'b0, '0);
            blob_no++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
